// ===== rtl/mcs_pkg.sv =====
// Shared types and constants for the multirail chunk splitter.
// Used by the controller, datapath, divider and align units; no dependencies.
package mcs_pkg;

  localparam int LEN_W      = 32;  // message and chunk lengths
  localparam int BW_W       = 16;  // rail bandwidth entry
  localparam int IDX_W      = 3;   // rail / chunk index
  localparam int CNT_W      = 4;   // chunk count
  localparam int SUM_W      = 19;  // sum of up to eight bandwidth entries
  localparam int PROD_W     = 48;  // quotient times bandwidth
  localparam int MAX_CHUNKS = 8;   // results per split, upper bound
  localparam int DIV_STEPS  = 32;  // one quotient bit per step
  localparam int DIV_CNT_W  = 5;
  localparam int ALN_DIG    = 8;   // bits folded into the remainder per step
  localparam int ALN_STEPS  = PROD_W / ALN_DIG;
  localparam int ALN_CNT_W  = 3;

  localparam logic KIND_BW    = 1'b0;
  localparam logic KIND_SPLIT = 1'b1;

  localparam logic MODE_EVEN   = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ALN_QUOT,
    ALN_PROD,
    ALN_PEND
  } aln_sel_t;

  typedef struct packed {
    logic     wr_bw;
    logic     load;
    logic     sum_acc;
    logic     idx_clr;
    logic     div_start;
    logic     mul_go;
    logic     aln_start;
    aln_sel_t aln_sel;
    logic     emit_even_chunk;
    logic     emit_even_rest;
    logic     emit_w_chunk;
    logic     emit_w_last;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic idx_last;
    logic even_more;
    logic even_rest;
    logic div_done;
    logic aln_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/multirail_chunk_splitter_top.sv =====
// Multirail chunk splitter, top level.
// Instantiates mcs_ctrl and mcs_dp; types and constants from mcs_pkg.
//
// Input channel (in_valid / in_stall): one item is either a bandwidth entry
// (in_kind = 0: in_rail_bandwidth goes into table slot in_rail_index, no result)
// or a split request (in_kind = 1: in_total_length over in_chunk_count chunks).
// Result channel (out_valid / out_stall): one item per chunk, in chunk order,
// out_last set on the final one. A zero length in even mode gives no results.
// Config: cfg_wr_en / cfg_wr_data write split_mode (0 even, 1 weighted); write
// only while the block is idle.
// Flow: a bandwidth entry is written on acceptance; the next item is taken right after.
// A split holds in_stall high until its last chunk is in the output register.
// Divisions use a 32-step serial divider, roundings a 6-step remainder unit. Even
// mode divides and rounds once, then emits; weighted mode sums n entries, then per
// rail but the last divides, multiplies and rounds, and rounds the rest for the last.
// Receiver stall: the output register holds its item; the sequencer waits
// before loading the next chunk. The last chunk may wait there while the next
// input item is already taken.
// Reset (rst_n low, synchronous): controller idle, output empty, split_mode 0.
// The bandwidth table is not cleared; read only slots written since reset.
module multirail_chunk_splitter_top
  import mcs_pkg::*;
#(
  parameter int MAX_RAILS   = 8,
  parameter int ALIGN_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  input  logic [IDX_W-1:0] in_rail_index,
  input  logic [BW_W-1:0]  in_rail_bandwidth,
  input  logic [LEN_W-1:0] in_total_length,
  input  logic [CNT_W-1:0] in_chunk_count,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_chunk_index,
  output logic [LEN_W-1:0] out_chunk_length,
  output logic             out_last
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: decides what the datapath does each cycle
  mcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // datapath: table, divider, multiplier, align unit, output register
  mcs_dp #(
    .MAX_RAILS   (MAX_RAILS),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_rail_index     (in_rail_index),
    .in_rail_bandwidth (in_rail_bandwidth),
    .in_total_length   (in_total_length),
    .in_chunk_count    (in_chunk_count),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_chunk_index   (out_chunk_index),
    .out_chunk_length  (out_chunk_length),
    .out_last          (out_last)
  );

endmodule

// ===== rtl/mcs_div.sv =====
// Restoring serial divider: one quotient bit per cycle.
// Depends on mcs_pkg; a zero divisor gives a zero quotient.
module mcs_div
  import mcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [LEN_W-1:0] dividend,
  input  logic [SUM_W-1:0] divisor,
  output logic             done,
  output logic [LEN_W-1:0] quot
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [LEN_W-1:0]     dvd_r;
  logic [SUM_W-1:0]     dvs_r;
  logic [SUM_W-1:0]     rem_r;
  logic                 zero_r;

  logic [SUM_W:0]       trial;
  logic                 ge;
  logic [SUM_W:0]       diff;

  always_comb begin
    trial = {rem_r, dvd_r[LEN_W-1]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      rem_r <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      dvd_r <= {dvd_r[LEN_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = zero_r ? '0 : dvd_r;

endmodule

// ===== rtl/mcs_aln.sv =====
// Align-up unit: remainder by ALIGN_BYTES, ALN_DIG bits per cycle, then round up
// and saturate to 32 bits. Depends on mcs_pkg.
module mcs_aln
  import mcs_pkg::*;
#(
  parameter int ALIGN_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] x,
  output logic              done,
  output logic [LEN_W-1:0]  res
);

  localparam int AW = $clog2(ALIGN_BYTES + 1);
  localparam logic [AW:0] A_V = (AW + 1)'(ALIGN_BYTES);

  logic                 busy_r;
  logic                 done_r;
  logic [ALN_CNT_W-1:0] cnt_r;
  logic [PROD_W-1:0]    x_r;
  logic [PROD_W-1:0]    sh_r;
  logic [AW-1:0]        rem_r;
  logic [AW-1:0]        rem_nxt;

  logic [AW:0]          t_v;
  logic [AW-1:0]        r_v;
  logic [AW:0]          pad;
  logic [PROD_W:0]      sum;

  // fold ALN_DIG bits, MSB first, into the running remainder
  always_comb begin
    r_v = rem_r;
    t_v = '0;
    for (int j = 0; j < ALN_DIG; j++) begin
      t_v = {r_v, sh_r[PROD_W-1-j]};
      if (t_v >= A_V) begin
        t_v = t_v - A_V;
      end
      r_v = t_v[AW-1:0];
    end
    rem_nxt = r_v;
  end

  always_comb begin
    pad = (rem_r == '0) ? '0 : (A_V - {1'b0, rem_r});
    sum = {1'b0, x_r} + (PROD_W + 1)'(pad);
    res = (sum[PROD_W:LEN_W] != '0) ? '1 : sum[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ALN_CNT_W'(ALN_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      sh_r  <= x;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_r << ALN_DIG;
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/mcs_dp.sv =====
// Datapath: split_mode register, bandwidth table, working registers, divider,
// multiplier, align unit and output register. Depends on mcs_pkg, mcs_div, mcs_aln.
module mcs_dp
  import mcs_pkg::*;
#(
  parameter int MAX_RAILS   = 8,
  parameter int ALIGN_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic [IDX_W-1:0] in_rail_index,
  input  logic [BW_W-1:0]  in_rail_bandwidth,
  input  logic [LEN_W-1:0] in_total_length,
  input  logic [CNT_W-1:0] in_chunk_count,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_chunk_index,
  output logic [LEN_W-1:0] out_chunk_length,
  output logic             out_last
);

  localparam int TBL_DEPTH = (MAX_RAILS < MAX_CHUNKS) ? MAX_RAILS : MAX_CHUNKS;
  localparam int TI_W      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CAP_N   = CNT_W'(TBL_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_V = (IDX_W + 1)'(TBL_DEPTH);

  logic             mode_r;
  logic [BW_W-1:0]  bw_tab_r [TBL_DEPTH];

  logic [LEN_W-1:0] len_r;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] idx_r;
  logic [LEN_W-1:0] assigned_r;
  logic [LEN_W-1:0] pending_r;
  logic [SUM_W-1:0] sum_r;
  logic [PROD_W-1:0] prod_r;
  logic [LEN_W-1:0] c_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_last_r;

  logic [BW_W-1:0]  rb;
  logic [CNT_W-1:0] n_clamp;
  logic [CNT_W-1:0] idx_p1;
  logic [LEN_W:0]   even_next;
  logic             emit_any;
  logic             out_free;

  logic [LEN_W-1:0] div_dividend;
  logic [SUM_W-1:0] div_divisor;
  logic             div_done;
  logic [LEN_W-1:0] quot;

  logic [PROD_W-1:0] aln_x;
  logic              aln_done;
  logic [LEN_W-1:0]  aln_res;

  assign rb = bw_tab_r[idx_r[TI_W-1:0]];

  always_comb begin
    if (in_chunk_count == '0) begin
      n_clamp = CNT_W'(1);
    end else if (in_chunk_count > CAP_N) begin
      n_clamp = CAP_N;
    end else begin
      n_clamp = in_chunk_count;
    end
  end

  assign idx_p1    = {1'b0, idx_r} + CNT_W'(1);
  assign even_next = {1'b0, assigned_r} + {1'b0, c_r};
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_any  = cmd.emit_even_chunk || cmd.emit_even_rest ||
                     cmd.emit_w_chunk || cmd.emit_w_last;

  always_comb begin
    sts.mode      = mode_r;
    sts.idx_last  = (idx_p1 == n_r);
    sts.even_more = (idx_p1 < n_r) && (even_next < {1'b0, len_r});
    sts.even_rest = (assigned_r < len_r);
    sts.div_done  = div_done;
    sts.aln_done  = aln_done;
    sts.out_free  = out_free;
  end

  // divider operands: len / n in even mode, pending / sum in weighted mode
  assign div_dividend = (mode_r == MODE_WEIGHT) ? pending_r : len_r;
  assign div_divisor  = (mode_r == MODE_WEIGHT) ? sum_r : SUM_W'(n_r);

  always_comb begin
    unique case (cmd.aln_sel)
      ALN_QUOT: aln_x = PROD_W'(quot);
      ALN_PROD: aln_x = prod_r;
      ALN_PEND: aln_x = PROD_W'(pending_r);
      default:  aln_x = prod_r;
    endcase
  end

  mcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (quot)
  );

  mcs_aln #(
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_aln (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.aln_start),
    .x     (aln_x),
    .done  (aln_done),
    .res   (aln_res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_EVEN;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (emit_any) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      priority if (cmd.load || cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.sum_acc || cmd.emit_even_chunk || cmd.emit_w_chunk) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_bw && ({1'b0, in_rail_index} < DEPTH_V)) begin
      bw_tab_r[in_rail_index[TI_W-1:0]] <= in_rail_bandwidth;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r      <= in_total_length;
      n_r        <= n_clamp;
      assigned_r <= '0;
      pending_r  <= in_total_length;
      sum_r      <= '0;
    end else begin
      if (cmd.sum_acc) begin
        sum_r <= sum_r + SUM_W'(rb);
      end
      if (cmd.emit_even_chunk) begin
        assigned_r <= even_next[LEN_W-1:0];
      end
      if (cmd.emit_w_chunk) begin
        pending_r <= (pending_r > c_r) ? (pending_r - c_r) : '0;
        sum_r     <= sum_r - SUM_W'(rb);
      end
    end
    if (cmd.mul_go) begin
      prod_r <= quot * rb;
    end
    if (aln_done) begin
      c_r <= aln_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit_any) begin
      out_idx_r  <= idx_r;
      out_len_r  <= cmd.emit_even_rest ? (len_r - assigned_r) : c_r;
      out_last_r <= cmd.emit_even_rest || cmd.emit_w_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_index  = out_idx_r;
  assign out_chunk_length = out_len_r;
  assign out_last         = out_last_r;

endmodule

// ===== rtl/mcs_ctrl.sv =====
// Controller state machine: sequences table writes, sums, divides, multiplies,
// alignment and result emission. Depends on mcs_pkg.
module mcs_ctrl
  import mcs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_stall
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_WCHK,
    S_DIV,
    S_DIVW,
    S_MUL,
    S_ALN,
    S_ALNW,
    S_EEMIT,
    S_WEMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.aln_sel = ALN_PROD;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_SPLIT) begin
            cmd.load  = 1'b1;
            state_nxt = (sts.mode == MODE_WEIGHT) ? S_SUM : S_DIV;
          end else begin
            cmd.wr_bw = 1'b1;
          end
        end
      end
      S_SUM: begin
        cmd.sum_acc = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_WCHK;
        end
      end
      S_WCHK: begin
        state_nxt = sts.idx_last ? S_ALN : S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          state_nxt = (sts.mode == MODE_WEIGHT) ? S_MUL : S_ALN;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_ALN;
      end
      S_ALN: begin
        cmd.aln_start = 1'b1;
        if (sts.mode == MODE_EVEN) begin
          cmd.aln_sel = ALN_QUOT;
        end else if (sts.idx_last) begin
          cmd.aln_sel = ALN_PEND;
        end else begin
          cmd.aln_sel = ALN_PROD;
        end
        state_nxt = S_ALNW;
      end
      S_ALNW: begin
        if (sts.aln_done) begin
          state_nxt = (sts.mode == MODE_WEIGHT) ? S_WEMIT : S_EEMIT;
        end
      end
      S_EEMIT: begin
        priority if (sts.even_more) begin
          cmd.emit_even_chunk = sts.out_free;
        end else if (sts.even_rest) begin
          if (sts.out_free) begin
            cmd.emit_even_rest = 1'b1;
            state_nxt          = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WEMIT: begin
        if (sts.out_free) begin
          if (sts.idx_last) begin
            cmd.emit_w_last = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.emit_w_chunk = 1'b1;
            state_nxt        = S_WCHK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = stall_r;

endmodule

// ===== rtl/mcs_chk.sv =====
// Port-level checker for the chunk splitter, bound to the top level.
// Depends on mcs_pkg and multirail_chunk_splitter_top.
module mcs_chk
  import mcs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_kind,
  input logic             out_valid,
  input logic             out_stall,
  input logic [IDX_W-1:0] out_chunk_index,
  input logic [LEN_W-1:0] out_chunk_length,
  input logic             out_last
);

  // stalled result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_chunk_length) && $stable(out_chunk_index)
                               && $stable(out_last))
    else $error("result changed while stalled");

  // an accepted split request closes the input in the next cycle
  a_split_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_SPLIT) |=> in_stall)
    else $error("input open right after a split request");

  // a non-final chunk means the split is still in progress
  a_mid_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input open while a split is unfinished");

endmodule

bind multirail_chunk_splitter_top mcs_chk u_mcs_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_chunk_index  (out_chunk_index),
  .out_chunk_length (out_chunk_length),
  .out_last         (out_last)
);
